// ===== sv/mm_pkg.sv =====
package mm_pkg;

    localparam int IDX_W = 3;
    localparam int SIZE_W = 4;
    localparam int PORT_ELEM_W = 16;
    localparam int SUM_W = 40;
    localparam int TOK_W = 6;
    localparam int REG_IDX_W = 2;

    localparam logic [1:0] OP_WR_A = 2'd0;
    localparam logic [1:0] OP_WR_B = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_ROWS_A = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLS_B = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // one result position walking down the cell chain
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [TOK_W-1:0] row;
        logic [TOK_W-1:0] col;
    } tok_t;

    // element write into the stores spread over the cells
    typedef struct packed {
        logic             a_en;
        logic             b_en;
        logic [TOK_W-1:0] row;
        logic [TOK_W-1:0] col;
    } wr_t;

endpackage

// ===== sv/mm_intf.sv =====
interface mm_cmd_if;
    import mm_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [IDX_W-1:0]              row_index;
    logic [IDX_W-1:0]              col_index;
    logic signed [PORT_ELEM_W-1:0] element_value;

    modport source (output valid, opcode, row_index, col_index, element_value, input ready);
    modport sink (input valid, opcode, row_index, col_index, element_value, output ready);
endinterface

interface mm_res_if;
    import mm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] product_value;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic                    last_flag;

    modport source (output valid, product_value, out_row, out_col, last_flag, input ready);
    modport sink (input valid, product_value, out_row, out_col, last_flag, output ready);
endinterface

interface mm_cfg_if;
    import mm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/matrix_multiply.sv =====
// Matrix multiply C = A x B over a chain of MAX_DIM multiply-accumulate cells; cell k holds
// column k of A and row k of B. A load word (opcode 0 for A, 1 for B) is taken while idle
// and loads may come back to back. A compute word emits rows_a * cols_b results in row-major
// order, one per cycle once the chain is full and the output is not stalled; the first passes
// the sequencer register, the two register stages of each cell and the output register. The
// command channel is not ready from a compute word until its last result has been taken, and
// output stalls hold the whole chain. Sizes above MAX_DIM act as MAX_DIM; a zero row or column
// count yields nothing.
module matrix_multiply
    import mm_pkg::*;
#(
    parameter int MAX_DIM = 8,
    parameter int ELEM_WIDTH = 16
)
(
    input logic        clk,
    input logic        rst_n,
    mm_cmd_if.sink     cmd,
    mm_res_if.source   result,
    mm_cfg_if.sink     cfg
);

    localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam int CMP_W = ((DIM_W > IDX_W) ? DIM_W : IDX_W) + 1;
    localparam int SZ_W = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 1;

    logic [SIZE_W-1:0] rows_a_reg;
    logic [SIZE_W-1:0] inner_len_reg;
    logic [SIZE_W-1:0] cols_b_reg;
    logic              busy_reg;
    logic              res_valid_reg;
    logic signed [SUM_W-1:0] res_value_reg;
    logic [IDX_W-1:0]  res_row_reg;
    logic [IDX_W-1:0]  res_col_reg;
    logic              res_last_reg;

    logic [CNT_W-1:0]  nr;
    logic [CNT_W-1:0]  nk;
    logic [CNT_W-1:0]  nc;
    logic              cmd_fire;
    logic              in_range;
    logic              start;
    logic              adv;
    wr_t               wr;
    logic signed [ELEM_WIDTH-1:0] wr_data;

    tok_t                    tok_chain [MAX_DIM + 1];
    logic signed [SUM_W-1:0] sum_chain [MAX_DIM + 1];

    function automatic logic [CNT_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
        if (SZ_W'(s) > SZ_W'(MAX_DIM))
        begin
            return CNT_W'(MAX_DIM);
        end
        return CNT_W'(s);
    endfunction

    assign nr = clamp_size(rows_a_reg);
    assign nk = clamp_size(inner_len_reg);
    assign nc = clamp_size(cols_b_reg);

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= SIZE_RESET;
            inner_len_reg <= SIZE_RESET;
            cols_b_reg <= SIZE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ROWS_A:    rows_a_reg <= cfg.data;
                REG_INNER_LEN: inner_len_reg <= cfg.data;
                REG_COLS_B:    cols_b_reg <= cfg.data;
                default:       ;
            endcase
        end
    end

    assign cmd.ready = !busy_reg;
    assign cmd_fire = cmd.valid && !busy_reg;

    assign in_range = (CMP_W'(cmd.row_index) < CMP_W'(MAX_DIM))
                   && (CMP_W'(cmd.col_index) < CMP_W'(MAX_DIM));

    assign wr.a_en = cmd_fire && in_range && cmd.opcode == OP_WR_A;
    assign wr.b_en = cmd_fire && in_range && cmd.opcode == OP_WR_B;
    assign wr.row = TOK_W'(cmd.row_index);
    assign wr.col = TOK_W'(cmd.col_index);
    // narrower stores keep the low bits, wider ones take the word as unsigned
    assign wr_data = ELEM_WIDTH'($unsigned(cmd.element_value));

    assign start = cmd_fire && cmd.opcode == OP_COMPUTE && nr != '0 && nc != '0;

    // the whole chain moves whenever the output register can take a word
    assign adv = !res_valid_reg || result.ready;

    mm_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .adv   (adv),
        .nr    (nr),
        .nc    (nc),
        .tok   (tok_chain[0])
    );

    assign sum_chain[0] = '0;

    for (genvar k = 0; k < MAX_DIM; k++)
    begin : g_cell
        mm_cell #(
            .MAX_DIM    (MAX_DIM),
            .ELEM_WIDTH (ELEM_WIDTH),
            .K          (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .nk      (nk),
            .wr      (wr),
            .wr_data (wr_data),
            .tok_in  (tok_chain[k]),
            .sum_in  (sum_chain[k]),
            .tok_out (tok_chain[k + 1]),
            .sum_out (sum_chain[k + 1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (res_valid_reg && result.ready && res_last_reg)
            begin
                busy_reg <= 1'b0;
            end
            if (adv)
            begin
                res_valid_reg <= tok_chain[MAX_DIM].valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_value_reg <= sum_chain[MAX_DIM];
            res_row_reg <= IDX_W'(tok_chain[MAX_DIM].row);
            res_col_reg <= IDX_W'(tok_chain[MAX_DIM].col);
            res_last_reg <= tok_chain[MAX_DIM].last;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.product_value = res_value_reg;
    assign result.out_row = res_row_reg;
    assign result.out_col = res_col_reg;
    assign result.last_flag = res_last_reg;

`ifndef SYNTHESIS
    a_result_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> busy_reg)
        else $error("result word outside a compute");

    a_last_ends_compute: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && result.ready && res_last_reg) |=> !busy_reg)
        else $error("still busy after last result word");

    a_walk_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tok_chain[0].valid |-> busy_reg)
        else $error("sequencer walking while idle");

    a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !(wr.a_en || wr.b_en))
        else $error("store write during compute");
`endif

endmodule

// ===== sv/mm_cell.sv =====
module mm_cell
    import mm_pkg::*;
#(
    parameter int MAX_DIM = 8,
    parameter int ELEM_WIDTH = 16,
    parameter int K = 0
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic [$clog2(MAX_DIM + 1)-1:0]  nk,
    input  wr_t                             wr,
    input  logic signed [ELEM_WIDTH-1:0]    wr_data,
    input  tok_t                            tok_in,
    input  logic signed [SUM_W-1:0]         sum_in,
    output tok_t                            tok_out,
    output logic signed [SUM_W-1:0]         sum_out
);

    localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int ADD_W = ((SUM_W > PROD_W) ? SUM_W : PROD_W) + 1;
    localparam logic signed [ADD_W-1:0] SAT_HI = ADD_W'({1'b0, {(SUM_W - 1){1'b1}}});
    localparam logic signed [ADD_W-1:0] SAT_LO = -SAT_HI - ADD_W'(1);

    // column K of A and row K of B
    logic signed [ELEM_WIDTH-1:0] a_col_reg [MAX_DIM];
    logic signed [ELEM_WIDTH-1:0] b_row_reg [MAX_DIM];

    tok_t                      tok1_reg;
    tok_t                      tok2_reg;
    logic signed [SUM_W-1:0]   sum1_reg;
    logic signed [SUM_W-1:0]   sum2_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ELEM_WIDTH-1:0] a_sel;
    logic signed [ELEM_WIDTH-1:0] b_sel;
    logic signed [ADD_W-1:0]   add_full;
    logic signed [SUM_W-1:0]   sum2_next;
    logic                      active;

    assign active = CNT_W'(K) < nk;
    assign a_sel = a_col_reg[tok_in.row[DIM_W-1:0]];
    assign b_sel = b_row_reg[tok_in.col[DIM_W-1:0]];

    always_ff @(posedge clk)
    begin
        if (wr.a_en && wr.col == TOK_W'(K))
        begin
            a_col_reg[wr.row[DIM_W-1:0]] <= wr_data;
        end
        if (wr.b_en && wr.row == TOK_W'(K))
        begin
            b_row_reg[wr.col[DIM_W-1:0]] <= wr_data;
        end
    end

    // saturate after each addition, same order as k rises along the chain
    always_comb
    begin
        add_full = ADD_W'(sum1_reg) + ADD_W'(prod_reg);
        if (!active)
        begin
            sum2_next = sum1_reg;
        end
        else if (add_full > SAT_HI)
        begin
            sum2_next = SUM_W'(SAT_HI);
        end
        else if (add_full < SAT_LO)
        begin
            sum2_next = SUM_W'(SAT_LO);
        end
        else
        begin
            sum2_next = SUM_W'(add_full);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok1_reg <= '0;
            tok2_reg <= '0;
        end
        else if (adv)
        begin
            tok1_reg <= tok_in;
            tok2_reg <= tok1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= a_sel * b_sel;
            sum1_reg <= sum_in;
            sum2_reg <= sum2_next;
        end
    end

    assign tok_out = tok2_reg;
    assign sum_out = sum2_reg;

endmodule

// ===== sv/mm_seq.sv =====
module mm_seq
    import mm_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            adv,
    input  logic [$clog2(MAX_DIM + 1)-1:0]  nr,
    input  logic [$clog2(MAX_DIM + 1)-1:0]  nc,
    output tok_t                            tok
);

    localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W = $clog2(MAX_DIM + 1);

    logic             active_reg;
    logic [DIM_W-1:0] r_reg;
    logic [DIM_W-1:0] c_reg;
    logic             row_end;
    logic             col_end;

    assign col_end = (CNT_W'(c_reg) + CNT_W'(1)) == nc;
    assign row_end = (CNT_W'(r_reg) + CNT_W'(1)) == nr;

    assign tok.valid = active_reg;
    assign tok.last = row_end && col_end;
    assign tok.row = TOK_W'(r_reg);
    assign tok.col = TOK_W'(c_reg);

    // row-major walk over the result, one position per advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            r_reg <= '0;
            c_reg <= '0;
        end
        else if (start)
        begin
            active_reg <= 1'b1;
            r_reg <= '0;
            c_reg <= '0;
        end
        else if (active_reg && adv)
        begin
            if (col_end)
            begin
                c_reg <= '0;
                r_reg <= r_reg + DIM_W'(1);
                if (row_end)
                begin
                    active_reg <= 1'b0;
                end
            end
            else
            begin
                c_reg <= c_reg + DIM_W'(1);
            end
        end
    end

endmodule

// ===== verif/mm_product_checker.sv =====
`timescale 1ns / 100ps

module mm_product_checker
    import mm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mm_cmd_if    cmd,
    mm_res_if    result,
    mm_cfg_if    cfg,
    output int   failures,
    output int   outstanding,
    output int   checked
);

    localparam int MAX_DIM = 8;
    localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;

    typedef struct {
        logic signed [SUM_W-1:0] value;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic                    last;
    } product_t;

    logic signed [PORT_ELEM_W-1:0] a_copy [MAX_DIM*MAX_DIM];
    logic signed [PORT_ELEM_W-1:0] b_copy [MAX_DIM*MAX_DIM];
    logic [SIZE_W-1:0]             rows_q;
    logic [SIZE_W-1:0]             inner_q;
    logic [SIZE_W-1:0]             cols_q;
    product_t                      expected_products [$];

    function automatic int clip_size(input logic [SIZE_W-1:0] s);
        return (s > MAX_DIM) ? MAX_DIM : int'(s);
    endfunction

    // row-major walk over C, each sum built in k order with saturation
    task automatic predict_products();
        int       nr;
        int       nk;
        int       nc;
        longint   acc;
        product_t p;
        nr = clip_size(rows_q);
        nk = clip_size(inner_q);
        nc = clip_size(cols_q);
        for (int r = 0; r < nr; r++)
        begin
            for (int c = 0; c < nc; c++)
            begin
                acc = 0;
                for (int k = 0; k < nk; k++)
                begin
                    acc += longint'(a_copy[r*MAX_DIM+k]) * longint'(b_copy[k*MAX_DIM+c]);
                    if (acc > SUM_HI)
                        acc = SUM_HI;
                    else if (acc < SUM_LO)
                        acc = SUM_LO;
                end
                p.value = acc[SUM_W-1:0];
                p.row = r[IDX_W-1:0];
                p.col = c[IDX_W-1:0];
                p.last = (r == nr - 1) && (c == nc - 1);
                expected_products.push_back(p);
            end
        end
    endtask

    task automatic check_product();
        product_t want;
        checked++;
        if (expected_products.size() == 0)
        begin
            failures++;
            $display("%0t: unexpected word, value %0d row %0d col %0d last %0b", $time,
                     result.product_value, result.out_row, result.out_col, result.last_flag);
            return;
        end
        want = expected_products.pop_front();
        if (result.product_value !== want.value || result.out_row !== want.row ||
            result.out_col !== want.col || result.last_flag !== want.last)
        begin
            failures++;
            $display("%0t: mismatch, expected value %0d row %0d col %0d last %0b", $time,
                     want.value, want.row, want.col, want.last);
            $display("%0t:           got value %0d row %0d col %0d last %0b", $time,
                     result.product_value, result.out_row, result.out_col, result.last_flag);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_q = SIZE_RESET;
            inner_q = SIZE_RESET;
            cols_q = SIZE_RESET;
            for (int i = 0; i < MAX_DIM * MAX_DIM; i++)
            begin
                a_copy[i] = '0;
                b_copy[i] = '0;
            end
            expected_products.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_ROWS_A:    rows_q = cfg.data;
                    REG_INNER_LEN: inner_q = cfg.data;
                    REG_COLS_B:    cols_q = cfg.data;
                    default:       ;
                endcase
            end
            if (cmd.valid && cmd.ready)
            begin
                case (cmd.opcode)
                    OP_WR_A:    a_copy[cmd.row_index*MAX_DIM+cmd.col_index] = cmd.element_value;
                    OP_WR_B:    b_copy[cmd.row_index*MAX_DIM+cmd.col_index] = cmd.element_value;
                    OP_COMPUTE: predict_products();
                    default:    ;
                endcase
            end
            if (result.valid && result.ready)
                check_product();
            outstanding = expected_products.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import mm_pkg::*;

    localparam logic [1:0]           OP_UNUSED = 2'd3;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int MAX_DIM = 8;
    localparam int TARGET_WORDS = 200;
    localparam int PHASE_WORDS = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT = 2000;

    logic clk;
    logic rst_n;

    mm_cmd_if cmd_if();
    mm_res_if res_if();
    mm_cfg_if cfg_if();

    int failures;
    int outstanding;
    int checked;
    int quiet_cycles;
    int words_sent;
    int settings_used;
    int n_rows;
    int n_inner;
    int n_cols;
    bit sender_idles;
    bit receiver_stalls;
    bit a_written [MAX_DIM*MAX_DIM];
    bit b_written [MAX_DIM*MAX_DIM];

    matrix_multiply DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    mm_product_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_if),
        .result      (res_if),
        .cfg         (cfg_if),
        .failures    (failures),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (receiver_stalls)
            res_if.ready <= ($urandom_range(0, 99) >= 34);
        else
            res_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int clip_dim(input int s);
        return (s > MAX_DIM) ? MAX_DIM : s;
    endfunction

    function automatic logic signed [PORT_ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3:       return '1;
            default: return PORT_ELEM_W'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col,
                             input logic signed [PORT_ELEM_W-1:0] value);
        while (sender_idles && $urandom_range(0, 99) < 34)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.opcode <= op;
        cmd_if.row_index <= row;
        cmd_if.col_index <= col;
        cmd_if.element_value <= value;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        words_sent++;
        if (op == OP_WR_A)
            a_written[row*MAX_DIM+col] = 1'b1;
        else if (op == OP_WR_B)
            b_written[row*MAX_DIM+col] = 1'b1;
    endtask

    // load every operand entry the product will read that was never written, then compute
    task automatic compute_product();
        if (n_rows > 0 && n_cols > 0)
        begin
            for (int r = 0; r < n_rows; r++)
                for (int k = 0; k < n_inner; k++)
                    if (!a_written[r*MAX_DIM+k])
                        send_word(OP_WR_A, IDX_W'(r), IDX_W'(k), rand_elem());
            for (int k = 0; k < n_inner; k++)
                for (int c = 0; c < n_cols; c++)
                    if (!b_written[k*MAX_DIM+c])
                        send_word(OP_WR_B, IDX_W'(k), IDX_W'(c), rand_elem());
        end
        send_word(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), PORT_ELEM_W'($urandom));
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
    endtask

    task automatic configure(input int r, input int k, input int c);
        drain();
        write_reg(REG_UNUSED, SIZE_W'($urandom));
        write_reg(REG_ROWS_A, r[SIZE_W-1:0]);
        write_reg(REG_INNER_LEN, k[SIZE_W-1:0]);
        write_reg(REG_COLS_B, c[SIZE_W-1:0]);
        cfg_if.valid <= 1'b0;
        n_rows = clip_dim(r);
        n_inner = clip_dim(k);
        n_cols = clip_dim(c);
        settings_used++;
    endtask

    task automatic random_phase();
        int             done;
        int             pick;
        int             lim_row;
        int             lim_col;
        logic [1:0]     op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        done = 0;
        while (done < PHASE_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                send_word(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom),
                          PORT_ELEM_W'($urandom));
            end
            else if (pick < 85)
            begin
                op = $urandom_range(0, 1) ? OP_WR_B : OP_WR_A;
                lim_row = (op == OP_WR_A) ? n_rows : n_inner;
                lim_col = (op == OP_WR_A) ? n_inner : n_cols;
                if (lim_row == 0)
                    lim_row = MAX_DIM;
                if (lim_col == 0)
                    lim_col = MAX_DIM;
                // some writes land outside the configured shape
                if ($urandom_range(0, 4) == 0)
                begin
                    row = IDX_W'($urandom_range(0, MAX_DIM - 1));
                    col = IDX_W'($urandom_range(0, MAX_DIM - 1));
                end
                else
                begin
                    row = IDX_W'($urandom_range(0, lim_row - 1));
                    col = IDX_W'($urandom_range(0, lim_col - 1));
                end
                send_word(op, row, col, rand_elem());
                done++;
            end
            else
            begin
                compute_product();
                done++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.opcode = OP_WR_A;
        cmd_if.row_index = '0;
        cmd_if.col_index = '0;
        cmd_if.element_value = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_ROWS_A;
        cfg_if.data = '0;
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
        n_rows = MAX_DIM;
        n_inner = MAX_DIM;
        n_cols = MAX_DIM;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // full-length dot product of most negative values gives the largest sum
        configure(1, MAX_DIM, 1);
        for (int k = 0; k < MAX_DIM; k++)
        begin
            send_word(OP_WR_A, 3'd0, IDX_W'(k), 16'sh8000);
            send_word(OP_WR_B, IDX_W'(k), 3'd0, 16'sh8000);
        end
        compute_product();
        send_word(OP_UNUSED, 3'd7, 3'd7, 16'sh7fff);
        send_word(OP_WR_A, 3'd0, 3'd0, 16'sh7fff);
        send_word(OP_WR_B, 3'd7, 3'd0, 16'sh7fff);
        send_word(OP_WR_A, 3'd7, 3'd7, 16'sh0001);
        compute_product();
        configure(1, 0, 1);
        compute_product();
        configure(0, MAX_DIM, 1);
        compute_product();

        for (int phase = 0; words_sent < TARGET_WORDS; phase++)
        begin
            sender_idles = (phase != 1);
            receiver_stalls = (phase != 1);
            case (phase)
                0:       configure(1, 1, 1);
                1:       configure(8, 8, 8);
                2:       configure(15, 15, 15);
                3:       configure(0, 3, 4);
                4:       configure(3, 0, 5);
                5:       configure(2, 5, 0);
                6:       configure(4, 2, 7);
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                        configure($urandom_range(0, 15), $urandom_range(0, 15),
                                  $urandom_range(0, 15));
                    else
                        configure($urandom_range(1, 4), $urandom_range(1, 4),
                                  $urandom_range(1, 4));
                end
            endcase
            random_phase();
        end
        drain();

        $display("summary: %0d command words, %0d result words checked, %0d size settings",
                 words_sent, checked, settings_used);
        $display("summary: extreme operands, unused opcode and register, zero and oversize dims");
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mm_pkg.sv
sv/mm_intf.sv
sv/mm_cell.sv
sv/mm_seq.sv
sv/matrix_multiply.sv
verif/mm_product_checker.sv
verif/testbench.sv
